// ----- hw/rtl/double_ended_queue_defines.svh -----
// Assertion macros shared by the deque RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define DEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");
// Next-cycle implication.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");
`else
`define DEQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/deq_pkg.sv -----
// Types, constants and ring-pointer helpers for the deque.
// Depends on nothing; used by the interfaces and the top level.
package deq_pkg;

   localparam int DEPTH       = 16;
   localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int WORD_W      = 64;
   localparam int OP_W        = 3;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   typedef logic [OP_W-1:0]        op_type;
   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [PTR_W-1:0]       ptr_type;
   typedef logic [PTR_W:0]         ptr_sum_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [COUNT_OUT_W-1:0] count_out_type;
   typedef logic [STATUS_W-1:0]    status_type;

   localparam op_type OP_NONE       = 3'd0;
   localparam op_type OP_PUSH_FRONT = 3'd1;
   localparam op_type OP_PUSH_BACK  = 3'd2;
   localparam op_type OP_POP_FRONT  = 3'd3;
   localparam op_type OP_POP_BACK   = 3'd4;
   localparam op_type OP_REVERSE    = 3'd5;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   localparam ptr_sum_type DEPTH_SUM = ptr_sum_type'(DEPTH);
   localparam cnt_type     DEPTH_CNT = cnt_type'(DEPTH);
   localparam ptr_type     LAST_SLOT = ptr_type'(DEPTH - 1);

   // Fold a sum below twice the depth back into the ring.
   function automatic ptr_type ring_wrap(input ptr_sum_type sum);
      ptr_sum_type folded;
      folded = (sum >= DEPTH_SUM) ? (sum - DEPTH_SUM) : sum;
      return folded[PTR_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/deq_req_if.sv -----
// Request channel of the deque: valid/ready handshake with op and data word.
// Depends on deq_pkg.
interface deq_req_if;
   import deq_pkg::*;

   logic     valid;
   logic     ready;
   op_type   op;
   word_type data_word;

   modport source (output valid, output op, output data_word, input ready);
   modport sink   (input valid, input op, input data_word, output ready);
endinterface

// ----- hw/rtl/deq_rsp_if.sv -----
// Response channel of the deque: valid/ready handshake with the end words and status.
// Depends on deq_pkg.
interface deq_rsp_if;
   import deq_pkg::*;

   logic          valid;
   logic          ready;
   word_type      front_word;
   word_type      back_word;
   count_out_type entry_count;
   logic          is_empty;
   status_type    status;

   modport source (output valid, output front_word, output back_word, output entry_count,
                   output is_empty, output status, input ready);
   modport sink   (input valid, input front_word, input back_word, input entry_count,
                   input is_empty, input status, output ready);
endinterface

// ----- hw/rtl/deq_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module deq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// Deque top level: ring store in a RAM, pointer and count registers, result register.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_ram and the assertion macros.
//
// Usage
//  - req_chan carries one operation per beat: none, push front, push back,
//    pop front, pop back or reverse, with the word to push.
//  - rsp_chan returns one beat for every request beat: the front and back
//    words after the operation (zero when empty), the count, an empty flag
//    and a status (ok, push refused because full, pop ignored because empty).
//  - Steps per request: the write to the ring RAM at accept, the registered
//    read of both end slots, then the load of the response register, which
//    makes the response valid. The next request is taken once that load is done.
//  - A stalled receiver holds the response register; one further item may be
//    accepted and worked on meanwhile, and it waits in its load step until
//    the pending response beat leaves.
//  - Reset empties the deque, clears the direction flag and drops any
//    pending response. The RAM is not cleared: only written slots are read.
`include "double_ended_queue_defines.svh"

module double_ended_queue (
   input logic     clock,
   input logic     reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0]    state_ff, state_in;
   ptr_type       head_ff, head_in;
   cnt_type       count_ff, count_in;
   logic          rev_ff, rev_in;
   status_type    status_ff, status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   word_type      front_ff, back_ff;
   count_out_type count_out_ff;
   logic          empty_ff;
   status_type    rsp_status_ff;

   logic          accept;
   logic          load_go;
   logic          is_push, is_pop, at_front, first_side;
   ptr_type       head_dec, head_inc, tail_addr, last_addr;
   logic          wr_en;
   ptr_type       wr_addr;
   word_type      rd_first, rd_last;
   word_type      first_w, last_w;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign load_go        = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_chan.ready);

   // Decode the operation against the direction flag.
   assign is_push    = (req_chan.op == OP_PUSH_FRONT) || (req_chan.op == OP_PUSH_BACK);
   assign is_pop     = (req_chan.op == OP_POP_FRONT) || (req_chan.op == OP_POP_BACK);
   assign at_front   = (req_chan.op == OP_PUSH_FRONT) || (req_chan.op == OP_POP_FRONT);
   assign first_side = at_front != rev_ff;

   // Ring arithmetic on the physical pointers.
   assign head_dec  = (head_ff == '0) ? LAST_SLOT : head_ff - ptr_type'(1);
   assign head_inc  = (head_ff == LAST_SLOT) ? '0 : head_ff + ptr_type'(1);
   assign tail_addr = ring_wrap(ptr_sum_type'(head_ff) + ptr_sum_type'(count_ff));
   assign last_addr = ring_wrap(ptr_sum_type'(head_ff) + ptr_sum_type'(count_ff)
                                - ptr_sum_type'(1));

   // Apply the operation to the pointers, count and direction flag, and write the pushed word at accept.
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_addr;
      if (accept) begin
         status_in = STATUS_OK;
         if (is_push) begin
            if (count_ff >= DEPTH_CNT) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + cnt_type'(1);
               if (first_side) begin
                  head_in = head_dec;
                  wr_addr = head_dec;
               end
            end
         end else if (is_pop) begin
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - cnt_type'(1);
               if (first_side) begin
                  head_in = head_inc;
               end
            end
         end else if (req_chan.op == OP_REVERSE) begin
            rev_in = !rev_ff;
         end
      end
   end

   // Sequence: accept and write, read both ends, load the response register.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            if (load_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_chan.data_word),
      .rd_en     (state_ff == ST_READ),
      .rd_addr_a (head_ff),
      .rd_addr_b (last_addr),
      .rd_data_a (rd_first),
      .rd_data_b (rd_last)
   );

   // Empty deque reads zero at both ends.
   assign first_w = (count_ff == '0) ? '0 : rd_first;
   assign last_w  = (count_ff == '0) ? '0 : rd_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload: hold until the next load.
   always_ff @(posedge clock) begin
      if (load_go) begin
         front_ff      <= rev_ff ? last_w : first_w;
         back_ff       <= rev_ff ? first_w : last_w;
         count_out_ff  <= count_out_type'(count_ff);
         empty_ff      <= (count_ff == '0);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.front_word  = front_ff;
   assign rsp_chan.back_word   = back_ff;
   assign rsp_chan.entry_count = count_out_ff;
   assign rsp_chan.is_empty    = empty_ff;
   assign rsp_chan.status      = rsp_status_ff;

   `DEQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT)
   `DEQ_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == ST_READ)
   `DEQ_ASSERT_SAME(a_full_status, clock, reset, load_go && (status_ff == STATUS_FULL),
                    count_ff == DEPTH_CNT)
   `DEQ_ASSERT_SAME(a_empty_status, clock, reset, load_go && (status_ff == STATUS_EMPTY),
                    count_ff == '0)

endmodule
